/* rtl/buffer_pool_page_replacement_core_defines.svh */
// Assertion macros shared by the buffer pool replacement RTL
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// check a condition in the cycle it is raised
`define BPPR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// check a condition in the cycle after it is raised
`define BPPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/bppr_pkg.sv */
// Package: types, codes and defaults of the buffer pool replacement core
`default_nettype none
package bppr_pkg;
   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 20;

   localparam logic [2:0] OP_PIN   = 3'd0;
   localparam logic [2:0] OP_UNPIN = 3'd1;
   localparam logic [2:0] OP_DIRTY = 3'd2;
   localparam logic [2:0] OP_FORCE = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_LOADED   = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_PINNED   = 2'd3;

   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_LRU   = 2'd1;
   localparam logic [1:0] POL_LFU   = 2'd2;
   localparam logic [1:0] POL_CLOCK = 2'd3;

   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_HIT   = 3'd1;
   localparam logic [2:0] ACT_LOAD  = 3'd2;
   localparam logic [2:0] ACT_UNPIN = 3'd3;
   localparam logic [2:0] ACT_DIRTY = 3'd4;
   localparam logic [2:0] ACT_FORCE = 3'd5;
   localparam logic [2:0] ACT_FLUSH = 3'd6;

   typedef struct packed {
      logic        valid;
      logic [7:0]  pin;
      logic        dirty;
      logic [31:0] stamp;
      logic [15:0] uses;
      logic        cbit;
   } frame_type;
endpackage
`default_nettype wire

/* rtl/bppr_cell.sv */
// One frame cell of the rotating frame ring
`default_nettype none
module bppr_cell
   import bppr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire frame_type            frame_in,
   input  wire logic [PAGE_BITS-1:0] page_in,
   output frame_type                 frame_out,
   output logic      [PAGE_BITS-1:0] page_out
);
   frame_type                 frame_ff;
   logic      [PAGE_BITS-1:0] page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (shift) begin
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         page_ff <= page_in;
      end
   end

   assign frame_out = frame_ff;
   assign page_out  = page_ff;
endmodule
`default_nettype wire

/* rtl/buffer_pool_page_replacement_core.sv */
// Top level: buffer pool page replacement core
//
// Requests enter on req_ (operation, page number) and results leave on rsp_;
// tlast marks the final result of a request. The frames sit in a ring of
// cells that rotates by one frame each cycle while a request scans or
// applies, unless a flush result stalls it. A request takes one full
// rotation to scan (match, empty frame, victim per policy, flush extent),
// a decision state, a second rotation that applies the update and emits
// flush results, and, unless a flush emitted results, a response state
// that loads a single result. One request is handled at a time;
// req_tready is high only while idle, and a waiting result in the output
// register does not block the next request.
// A stalled receiver stops the ring during a flush until each result is
// taken, and holds the single result of other requests until it is taken.
// Reset empties every frame and clears hands, counter and policy.
// csr_wr_en writes the replacement policy; write it only while idle.
`default_nettype none
module buffer_pool_page_replacement_core
   import bppr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   localparam int IW       = $clog2(FRAMES),
   localparam int REQ_W    = ((3 + PAGE_BITS + 7) / 8) * 8,
   localparam int RSP_W    = ((4 + IW + PAGE_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // operation, page_number
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata,   // status, frame_index, read_request,
                                              // writeback_request, writeback_page
   output logic                  rsp_tlast,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_wr_data
);
`include "buffer_pool_page_replacement_core_defines.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;
   localparam logic [IW-1:0] LAST_K = IW'(FRAMES - 1);
   localparam logic [IW:0]   F_W    = (IW + 1)'(FRAMES);

   function automatic logic [IW-1:0] ring_dist(input logic [IW-1:0] k, input logic [IW-1:0] b);
      logic [IW:0] d;
      d = (k >= b) ? ({1'b0, k} - {1'b0, b}) : ({1'b0, k} + F_W - {1'b0, b});
      return d[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] v);
      return (v == LAST_K) ? '0 : v + 1'b1;
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [IW-1:0]        k_ff;
   logic [1:0]           policy_ff;
   logic [2:0]           op_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [31:0]          acc_ff;
   logic [IW-1:0]        fifo_hand_ff, lfu_start_ff, clock_hand_ff;

   logic m_found_ff, i_found_ff, any_unp_ff, fh_found_ff, fw_found_ff, l_found_ff;
   logic lh_found_ff, lw_found_ff, c0h_found_ff, c0w_found_ff, uh_found_ff, uw_found_ff;
   logic lf_found_ff;
   logic [IW-1:0] m_idx_ff, i_idx_ff, fh_idx_ff, fw_idx_ff, l_idx_ff, lh_idx_ff, lw_idx_ff;
   logic [IW-1:0] c0h_idx_ff, c0w_idx_ff, uh_idx_ff, uw_idx_ff, lf_idx_ff;
   logic [31:0]   l_stamp_ff;
   logic [15:0]   lh_use_ff, lw_use_ff;

   logic [2:0]           act_ff;
   logic [IW-1:0]        tgt_ff;
   logic                 repl_ff, clk_clr_ff, clr_all_ff;
   logic [IW-1:0]        clr_lim_ff, clr_base_ff;
   logic [1:0]           res_status_ff;
   logic [IW-1:0]        res_idx_ff;
   logic                 res_rd_ff, res_wb_ff;
   logic [PAGE_BITS-1:0] res_page_ff;

   logic [2:0]           act_in;
   logic                 acc_inc;
   logic [IW-1:0]        tgt_in;
   logic                 repl_in, clk_clr_in;
   logic [1:0]           res_status_in;
   logic [IW-1:0]        res_idx_in;
   logic                 res_rd_in, res_wb_in;
   logic [PAGE_BITS-1:0] res_page_in;

   logic                 rsp_tvalid_ff, rsp_last_ff, rsp_rd_ff, rsp_wb_ff;
   logic [1:0]           rsp_status_ff;
   logic [IW-1:0]        rsp_idx_ff;
   logic [PAGE_BITS-1:0] rsp_page_ff;

   frame_type            cell_frame [FRAMES];
   logic [PAGE_BITS-1:0] cell_page  [FRAMES];
   frame_type            head, mod_frame;
   logic [PAGE_BITS-1:0] head_page, mod_page;
   logic                 shift, out_free, fl_emit, unp, accept, out_load;
   logic [IW-1:0]        victim;

   assign head      = cell_frame[0];
   assign head_page = cell_page[0];
   assign unp       = (head.pin == 8'd0);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign fl_emit   = (act_ff == ACT_FLUSH) && head.valid && unp && head.dirty;
   assign shift     = (state_ff == S_SCAN) ||
                      ((state_ff == S_APPLY) && !(fl_emit && !out_free));
   assign out_load  = ((state_ff == S_APPLY) && fl_emit && out_free) ||
                      ((state_ff == S_RESP) && out_free);

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      bppr_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .frame_in  ((i == FRAMES - 1) ? mod_frame : cell_frame[(i + 1) % FRAMES]),
         .page_in   ((i == FRAMES - 1) ? mod_page : cell_page[(i + 1) % FRAMES]),
         .frame_out (cell_frame[i]),
         .page_out  (cell_page[i])
      );
   end

   always_comb begin
      mod_frame = head;
      mod_page  = head_page;
      if (state_ff == S_APPLY) begin
         if (clk_clr_ff && unp &&
             (clr_all_ff || (ring_dist(k_ff, clr_base_ff) < clr_lim_ff))) begin
            mod_frame.cbit = 1'b0;
         end
         if (fl_emit) begin
            mod_frame.dirty = 1'b0;
         end
         if (k_ff == tgt_ff) begin
            unique case (act_ff)
               ACT_HIT: begin
                  if (head.pin != 8'hFF) mod_frame.pin = head.pin + 8'd1;
                  mod_frame.stamp = acc_ff;
                  if (head.uses != 16'hFFFF) mod_frame.uses = head.uses + 16'd1;
                  mod_frame.cbit = 1'b1;
               end
               ACT_LOAD: begin
                  mod_page        = page_ff;
                  mod_frame.valid = 1'b1;
                  mod_frame.pin   = 8'd1;
                  mod_frame.dirty = 1'b0;
                  mod_frame.stamp = acc_ff;
                  mod_frame.uses  = 16'd0;
                  mod_frame.cbit  = 1'b1;
               end
               ACT_UNPIN: begin
                  if (head.pin != 8'd0) mod_frame.pin = head.pin - 8'd1;
               end
               ACT_DIRTY: mod_frame.dirty = 1'b1;
               ACT_FORCE: mod_frame.dirty = 1'b0;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (policy_ff)
         POL_FIFO:  victim = fh_found_ff ? fh_idx_ff : fw_idx_ff;
         POL_LRU:   victim = l_idx_ff;
         POL_LFU:   victim = (lh_found_ff && (!lw_found_ff || lw_use_ff >= lh_use_ff))
                             ? lh_idx_ff : lw_idx_ff;
         default:   victim = c0h_found_ff ? c0h_idx_ff :
                             c0w_found_ff ? c0w_idx_ff :
                             uh_found_ff  ? uh_idx_ff  : uw_idx_ff;
      endcase
   end

   always_comb begin
      act_in        = ACT_NONE;
      acc_inc       = 1'b0;
      tgt_in        = m_idx_ff;
      repl_in       = 1'b0;
      clk_clr_in    = 1'b0;
      res_status_in = ST_DONE;
      res_idx_in    = '0;
      res_rd_in     = 1'b0;
      res_wb_in     = 1'b0;
      res_page_in   = '0;
      unique case (op_ff)
         OP_PIN: begin
            if (m_found_ff) begin
               act_in     = ACT_HIT;
               acc_inc    = 1'b1;
               res_idx_in = m_idx_ff;
            end else if (i_found_ff || any_unp_ff) begin
               act_in        = ACT_LOAD;
               acc_inc       = 1'b1;
               tgt_in        = i_found_ff ? i_idx_ff : victim;
               res_idx_in    = i_found_ff ? i_idx_ff : victim;
               repl_in       = !i_found_ff;
               clk_clr_in    = !i_found_ff && (policy_ff == POL_CLOCK);
               res_status_in = ST_LOADED;
               res_rd_in     = 1'b1;
            end else begin
               res_status_in = ST_PINNED;
            end
         end
         OP_UNPIN, OP_DIRTY, OP_FORCE: begin
            if (m_found_ff) begin
               res_idx_in = m_idx_ff;
               if (op_ff == OP_UNPIN) begin
                  act_in = ACT_UNPIN;
               end else if (op_ff == OP_DIRTY) begin
                  act_in = ACT_DIRTY;
               end else begin
                  act_in      = ACT_FORCE;
                  res_wb_in   = 1'b1;
                  res_page_in = page_ff;
               end
            end else begin
               res_status_in = ST_NOTFOUND;
            end
         end
         OP_FLUSH: if (lf_found_ff) act_in = ACT_FLUSH;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_SCAN;
         S_SCAN:   if (k_ff == LAST_K) state_in = S_DECIDE;
         S_DECIDE: state_in = S_APPLY;
         S_APPLY:  if (shift && k_ff == LAST_K) state_in = (act_ff == ACT_FLUSH) ? S_IDLE : S_RESP;
         S_RESP:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= '0;
         policy_ff     <= POL_FIFO;
         acc_ff        <= '0;
         fifo_hand_ff  <= '0;
         lfu_start_ff  <= '0;
         clock_hand_ff <= '0;
         act_ff        <= ACT_NONE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) policy_ff <= csr_wr_data;
         if (accept || (shift && k_ff == LAST_K)) begin
            k_ff <= '0;
         end else if (shift) begin
            k_ff <= k_ff + 1'b1;
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (state_ff == S_DECIDE) begin
            act_ff <= act_in;
            if (acc_inc) acc_ff <= acc_ff + 32'd1;
            if (repl_in) begin
               unique case (policy_ff)
                  POL_FIFO:  fifo_hand_ff  <= inc_wrap(victim);
                  POL_LFU:   lfu_start_ff  <= inc_wrap(victim);
                  POL_CLOCK: clock_hand_ff <= inc_wrap(victim);
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_tdata[2:0];
         page_ff      <= req_tdata[PAGE_BITS+2:3];
         m_found_ff   <= 1'b0;
         i_found_ff   <= 1'b0;
         any_unp_ff   <= 1'b0;
         fh_found_ff  <= 1'b0;
         fw_found_ff  <= 1'b0;
         l_found_ff   <= 1'b0;
         lh_found_ff  <= 1'b0;
         lw_found_ff  <= 1'b0;
         c0h_found_ff <= 1'b0;
         c0w_found_ff <= 1'b0;
         uh_found_ff  <= 1'b0;
         uw_found_ff  <= 1'b0;
         lf_found_ff  <= 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (!m_found_ff && head.valid && head_page == page_ff) begin
            m_found_ff <= 1'b1;
            m_idx_ff   <= k_ff;
         end
         if (!i_found_ff && !head.valid) begin
            i_found_ff <= 1'b1;
            i_idx_ff   <= k_ff;
         end
         if (unp) begin
            any_unp_ff <= 1'b1;
            if (!fh_found_ff && k_ff >= fifo_hand_ff) begin
               fh_found_ff <= 1'b1;
               fh_idx_ff   <= k_ff;
            end
            if (!fw_found_ff) begin
               fw_found_ff <= 1'b1;
               fw_idx_ff   <= k_ff;
            end
            if (!l_found_ff || head.stamp < l_stamp_ff) begin
               l_found_ff <= 1'b1;
               l_idx_ff   <= k_ff;
               l_stamp_ff <= head.stamp;
            end
            if (k_ff >= lfu_start_ff) begin
               if (!lh_found_ff || head.uses < lh_use_ff) begin
                  lh_found_ff <= 1'b1;
                  lh_idx_ff   <= k_ff;
                  lh_use_ff   <= head.uses;
               end
            end else if (!lw_found_ff || head.uses < lw_use_ff) begin
               lw_found_ff <= 1'b1;
               lw_idx_ff   <= k_ff;
               lw_use_ff   <= head.uses;
            end
            if (k_ff >= clock_hand_ff) begin
               if (!c0h_found_ff && !head.cbit) begin
                  c0h_found_ff <= 1'b1;
                  c0h_idx_ff   <= k_ff;
               end
               if (!uh_found_ff) begin
                  uh_found_ff <= 1'b1;
                  uh_idx_ff   <= k_ff;
               end
            end else begin
               if (!c0w_found_ff && !head.cbit) begin
                  c0w_found_ff <= 1'b1;
                  c0w_idx_ff   <= k_ff;
               end
               if (!uw_found_ff) begin
                  uw_found_ff <= 1'b1;
                  uw_idx_ff   <= k_ff;
               end
            end
            if (head.valid && head.dirty) begin
               lf_found_ff <= 1'b1;
               lf_idx_ff   <= k_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DECIDE) begin
         tgt_ff        <= tgt_in;
         repl_ff       <= repl_in;
         clk_clr_ff    <= clk_clr_in;
         clr_all_ff    <= !(c0h_found_ff || c0w_found_ff);
         clr_base_ff   <= clock_hand_ff;
         clr_lim_ff    <= ring_dist(victim, clock_hand_ff);
         res_status_ff <= res_status_in;
         res_idx_ff    <= res_idx_in;
         res_rd_ff     <= res_rd_in;
         res_wb_ff     <= res_wb_in;
         res_page_ff   <= res_page_in;
      end else if (state_ff == S_APPLY && act_ff == ACT_LOAD && repl_ff && k_ff == tgt_ff) begin
         res_wb_ff   <= head.dirty;
         res_page_ff <= head.dirty ? head_page : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == S_APPLY) begin
            rsp_status_ff <= ST_DONE;
            rsp_idx_ff    <= k_ff;
            rsp_rd_ff     <= 1'b0;
            rsp_wb_ff     <= 1'b1;
            rsp_page_ff   <= head_page;
            rsp_last_ff   <= (k_ff == lf_idx_ff);
         end else begin
            rsp_status_ff <= res_status_ff;
            rsp_idx_ff    <= res_idx_ff;
            rsp_rd_ff     <= res_rd_ff;
            rsp_wb_ff     <= res_wb_ff;
            rsp_page_ff   <= res_page_ff;
            rsp_last_ff   <= 1'b1;
         end
      end
   end

   always_comb begin
      rsp_tdata                    = '0;
      rsp_tdata[1:0]               = rsp_status_ff;
      rsp_tdata[IW+1:2]            = rsp_idx_ff;
      rsp_tdata[IW+2]              = rsp_rd_ff;
      rsp_tdata[IW+3]              = rsp_wb_ff;
      rsp_tdata[IW+PAGE_BITS+3:IW+4] = rsp_page_ff;
   end
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BPPR_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, (state_ff == S_SCAN) && (k_ff == '0))
   `BPPR_ASSERT_NEXT(a_decide_then_apply, clock, reset, state_ff == S_DECIDE, state_ff == S_APPLY)
   `BPPR_ASSERT_SAME(a_load_only_when_free, clock, reset, out_load, out_free)
   `BPPR_ASSERT_SAME(a_flush_stalls_ring, clock, reset, (state_ff == S_APPLY) && fl_emit && !out_free, !shift)
endmodule
`default_nettype wire
